[design/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the I2C master SDA sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // command codes carried by a request transaction (6 and 7 act as none)
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_BYTE    = 3'd3,
      CMD_ADDRESS = 3'd4,
      CMD_WORD    = 3'd5
   } command_type;

   // sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ST_D1 = 4'd1,
      PH_ST_WH = 4'd2,
      PH_ST_D2 = 4'd3,
      PH_ST_D3 = 4'd4,
      PH_SP_WH = 4'd5,
      PH_SP_D1 = 4'd6,
      PH_SP_D2 = 4'd7,
      PH_SP_WL = 4'd8,
      PH_WB_WH = 4'd9,
      PH_WB_WL = 4'd10,
      PH_WB_D  = 4'd11,
      PH_AK_WH = 4'd12,
      PH_AK_D1 = 4'd13,
      PH_AK_WL = 4'd14,
      PH_AK_D2 = 4'd15
   } phase_type;

   localparam logic [15:0] HOLD_TICKS_RESET = 16'd16;
   localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

   // one response transaction
   typedef struct packed {
      logic sda_drive;
      logic busy_res;
      logic done_res;
      logic nack;
   } result_type;

endpackage

[design/i2c_master_sda_sequencer_top.sv]
// A response is registered in the output register, or in the skid entry if
// the output is held. Throughput: one request per cycle unless stalled; the
// per-tick phase step is a single register-to-register pass through the phase
// decoder and the delay counter. A two-entry output buffer takes one more
// request while a response is held, then stalls until the held response leaves.
// Reset (synchronous, active high): phase idle, SDA released, hold delay 16,
// output buffer empty.
// ----------------------------------------------------------------------------
// i2c_master_sda_sequencer_top
// SDA sequencer for an I2C master following an external SCL: start, stop,
// byte, address and ten-bit word transmission with acknowledge sampling.
// ----------------------------------------------------------------------------
module i2c_master_sda_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_byte_value,
   input  logic [6:0]  req_address,
   input  logic        req_read_not_write,
   input  logic [9:0]  req_word_value,
   input  logic        req_scl_level,
   input  logic        req_sda_level,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_nack
);
   import i2cms_pkg::*;

   logic [15:0] hold_ticks_ff;
   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [7:0]  second_byte_ff, second_byte_in;
   logic        second_pending_ff, second_pending_in;
   logic [15:0] delay_count_ff, delay_count_in;
   logic        nack_flag_ff, nack_flag_in;
   logic        sda_out_ff, sda_out_in;
   logic        done_in;
   logic        delay_zero;
   command_type cmd;

   logic        req_accept, rsp_accept;
   result_type  result_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_data_ff, skid_data_in;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = out_valid_ff && !rsp_stall;
   assign req_stall  = skid_valid_ff;
   assign cmd        = command_type'(req_command);
   assign delay_zero = (delay_count_ff == 16'd0);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_TICKS_RESET;
      end else if (csr_write_enable) begin
         hold_ticks_ff <= csr_write_data;
      end
   end

   // phase step for one tick
   always_comb begin
      phase_in          = phase_ff;
      bit_count_in      = bit_count_ff;
      shift_byte_in     = shift_byte_ff;
      second_byte_in    = second_byte_ff;
      second_pending_in = second_pending_ff;
      delay_count_in    = delay_count_ff;
      nack_flag_in      = nack_flag_ff;
      sda_out_in        = sda_out_ff;
      done_in           = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            unique case (cmd)
               CMD_START: begin
                  sda_out_in     = 1'b1;
                  delay_count_in = hold_ticks_ff;
                  phase_in       = PH_ST_D1;
               end
               CMD_STOP: begin
                  sda_out_in = 1'b0;
                  phase_in   = PH_SP_WH;
               end
               CMD_BYTE: begin
                  nack_flag_in      = 1'b0;
                  second_pending_in = 1'b0;
                  shift_byte_in     = req_byte_value;
                  bit_count_in      = 4'd0;
                  phase_in          = PH_WB_WL;
               end
               CMD_ADDRESS: begin
                  nack_flag_in      = 1'b0;
                  second_pending_in = 1'b0;
                  shift_byte_in     = {req_address, req_read_not_write};
                  bit_count_in      = 4'd0;
                  phase_in          = PH_WB_WL;
               end
               CMD_WORD: begin
                  // word sits in bits 11:2 of two bytes, high byte first
                  nack_flag_in      = 1'b0;
                  second_byte_in    = {req_word_value[5:0], 2'b00};
                  second_pending_in = 1'b1;
                  shift_byte_in     = {4'b0000, req_word_value[9:6]};
                  bit_count_in      = 4'd0;
                  phase_in          = PH_WB_WL;
               end
               default: begin
               end
            endcase
         end
         PH_ST_D1: begin
            if (delay_zero) phase_in = PH_ST_WH;
            else delay_count_in = delay_count_ff - 16'd1;
         end
         PH_ST_WH: begin
            if (req_scl_level) begin
               delay_count_in = hold_ticks_ff;
               phase_in       = PH_ST_D2;
            end
         end
         PH_ST_D2: begin
            if (delay_zero) begin
               sda_out_in     = 1'b0;
               delay_count_in = hold_ticks_ff;
               phase_in       = PH_ST_D3;
            end else begin
               delay_count_in = delay_count_ff - 16'd1;
            end
         end
         PH_ST_D3: begin
            if (delay_zero) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               delay_count_in = delay_count_ff - 16'd1;
            end
         end
         PH_SP_WH: begin
            if (req_scl_level) begin
               delay_count_in = hold_ticks_ff;
               phase_in       = PH_SP_D1;
            end
         end
         PH_SP_D1: begin
            if (delay_zero) begin
               sda_out_in     = 1'b1;
               delay_count_in = hold_ticks_ff;
               phase_in       = PH_SP_D2;
            end else begin
               delay_count_in = delay_count_ff - 16'd1;
            end
         end
         PH_SP_D2: begin
            if (delay_zero) phase_in = PH_SP_WL;
            else delay_count_in = delay_count_ff - 16'd1;
         end
         PH_SP_WL: begin
            if (!req_scl_level) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         PH_WB_WH: begin
            if (req_scl_level) phase_in = PH_WB_WL;
         end
         PH_WB_WL: begin
            if (!req_scl_level) begin
               if (bit_count_ff >= BITS_PER_BYTE) begin
                  // release for the acknowledge bit
                  sda_out_in = 1'b1;
                  phase_in   = PH_AK_WH;
               end else begin
                  delay_count_in = hold_ticks_ff;
                  phase_in       = PH_WB_D;
               end
            end
         end
         PH_WB_D: begin
            if (delay_zero) begin
               sda_out_in    = shift_byte_ff[7];
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               bit_count_in  = bit_count_ff + 4'd1;
               phase_in      = PH_WB_WH;
            end else begin
               delay_count_in = delay_count_ff - 16'd1;
            end
         end
         PH_AK_WH: begin
            if (req_scl_level) begin
               delay_count_in = hold_ticks_ff;
               phase_in       = PH_AK_D1;
            end
         end
         PH_AK_D1: begin
            if (delay_zero) begin
               nack_flag_in = nack_flag_ff | req_sda_level;
               phase_in     = PH_AK_WL;
            end else begin
               delay_count_in = delay_count_ff - 16'd1;
            end
         end
         PH_AK_WL: begin
            if (!req_scl_level) begin
               delay_count_in = hold_ticks_ff;
               phase_in       = PH_AK_D2;
            end
         end
         PH_AK_D2: begin
            if (delay_zero) begin
               if (second_pending_ff) begin
                  second_pending_in = 1'b0;
                  shift_byte_in     = second_byte_ff;
                  bit_count_in      = 4'd0;
                  phase_in          = PH_WB_WL;
               end else begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            end else begin
               delay_count_in = delay_count_ff - 16'd1;
            end
         end
      endcase
   end

   // sequencer state, stepped once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         bit_count_ff      <= 4'd0;
         shift_byte_ff     <= 8'd0;
         second_byte_ff    <= 8'd0;
         second_pending_ff <= 1'b0;
         delay_count_ff    <= 16'd0;
         nack_flag_ff      <= 1'b0;
         sda_out_ff        <= 1'b1;
      end else if (req_accept) begin
         phase_ff          <= phase_in;
         bit_count_ff      <= bit_count_in;
         shift_byte_ff     <= shift_byte_in;
         second_byte_ff    <= second_byte_in;
         second_pending_ff <= second_pending_in;
         delay_count_ff    <= delay_count_in;
         nack_flag_ff      <= nack_flag_in;
         sda_out_ff        <= sda_out_in;
      end
   end

   // response for this tick: values after the step
   assign result_in.sda_drive = sda_out_in;
   assign result_in.busy_res  = (phase_in != PH_IDLE);
   assign result_in.done_res  = done_in;
   assign result_in.nack      = nack_flag_in;

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_accept) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (!out_valid_ff || rsp_accept) begin
            out_valid_in = 1'b1;
            out_data_in  = result_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_sda_drive = out_data_ff.sda_drive;
   assign rsp_busy_res  = out_data_ff.busy_res;
   assign rsp_done_res  = out_data_ff.done_res;
   assign rsp_nack      = out_data_ff.nack;

`ifndef NO_ASSERTIONS
   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a finishing command always lands back in idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.done_res) |-> !out_data_ff.busy_res)
      else $error("done reported while still busy");

   // after an accepted transaction the output register always holds a response next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> out_valid_ff)
      else $error("accepted transaction without response");

   // bit counter never runs past one byte
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BITS_PER_BYTE)
      else $error("bit counter out of range");
`endif

endmodule

[verif/tb_i2c_master_sda_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_sda_sequencer_top
// Self-checking bench for the I2C master SDA sequencer. Line-level ticks are
// fed with a toggling SCL and random SDA, and a behavioural copy of the
// sequencer predicts the response for every accepted tick. A start at the
// reset delay comes first, then directed stop, byte, address and word
// sequences at a short delay. Then framed random traffic runs under several
// hold delays and handshake idling patterns, and a single stop at a longer
// hold delay closes the run.
// ----------------------------------------------------------------------------
module tb_i2c_master_sda_sequencer_top;
   import i2cms_pkg::*;

   localparam int          CYCLE_LIMIT    = 2_000_000;
   localparam int          RANDOM_TICKS   = 100;
   localparam logic [2:0]  CMD_UNUSED_SIX = 3'd6;
   localparam logic [2:0]  CMD_UNUSED_SVN = 3'd7;

   // one request transaction: a sampled bus tick plus an optional command
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] byte_value;
      logic [6:0] address;
      logic       read_not_write;
      logic [9:0] word_value;
      logic       scl_level;
      logic       sda_level;
   } line_tick_type;

   // ------------------------------------------------------------------------
   // behavioural sequencer and store of expected responses
   // ------------------------------------------------------------------------
   class sda_sequence_scoreboard;
      logic [15:0] hold_ticks;
      phase_type   phase;
      logic [3:0]  bit_count;
      logic [7:0]  shift_byte;
      logic [7:0]  second_byte;
      logic        second_pending;
      logic [15:0] delay_count;
      logic        nack_flag;
      logic        sda_out;
      result_type  expected_responses[$];
      int          errors;
      int          mismatches;
      int          ticks;
      int          completions;
      int          nacked;
      int          commands_taken[8];

      function new();
         hold_ticks     = HOLD_TICKS_RESET;
         phase          = PH_IDLE;
         bit_count      = '0;
         shift_byte     = '0;
         second_byte    = '0;
         second_pending = 1'b0;
         delay_count    = '0;
         nack_flag      = 1'b0;
         sda_out        = 1'b1;
         errors         = 0;
         mismatches     = 0;
         ticks          = 0;
         completions    = 0;
         nacked         = 0;
         foreach (commands_taken[i]) commands_taken[i] = 0;
      endfunction

      function void set_hold(logic [15:0] value);
         hold_ticks = value;
      endfunction

      function bit is_idle();
         return phase == PH_IDLE;
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction

      // a delay phase counts down, its action falls on the tick after zero
      function bit delay_done();
         if (delay_count == 16'd0) return 1'b1;
         delay_count = delay_count - 16'd1;
         return 1'b0;
      endfunction

      function void enter_delay(phase_type next_phase);
         delay_count = hold_ticks;
         phase       = next_phase;
      endfunction

      function void begin_byte(logic [7:0] value);
         shift_byte = value;
         bit_count  = '0;
         phase      = PH_WB_WL;
      endfunction

      // advance one bus tick and queue the response it produces
      function void note_tick(line_tick_type t);
         logic       done;
         result_type r;
         done = 1'b0;
         ticks++;
         case (phase)
            PH_IDLE: begin
               commands_taken[t.command]++;
               if (t.command == CMD_START) begin
                  sda_out = 1'b1;
                  enter_delay(PH_ST_D1);
               end else if (t.command == CMD_STOP) begin
                  sda_out = 1'b0;
                  phase   = PH_SP_WH;
               end else if (t.command == CMD_BYTE) begin
                  nack_flag      = 1'b0;
                  second_pending = 1'b0;
                  begin_byte(t.byte_value);
               end else if (t.command == CMD_ADDRESS) begin
                  nack_flag      = 1'b0;
                  second_pending = 1'b0;
                  begin_byte({t.address, t.read_not_write});
               end else if (t.command == CMD_WORD) begin
                  // word sits in bits 11:2 of a two-byte frame, high byte first
                  nack_flag      = 1'b0;
                  second_byte    = {t.word_value[5:0], 2'b00};
                  second_pending = 1'b1;
                  begin_byte({4'b0000, t.word_value[9:6]});
               end
            end
            PH_ST_D1: if (delay_done()) phase = PH_ST_WH;
            PH_ST_WH: if (t.scl_level) enter_delay(PH_ST_D2);
            PH_ST_D2: begin
               if (delay_done()) begin
                  sda_out = 1'b0;
                  enter_delay(PH_ST_D3);
               end
            end
            PH_ST_D3: begin
               if (delay_done()) begin
                  phase = PH_IDLE;
                  done  = 1'b1;
               end
            end
            PH_SP_WH: if (t.scl_level) enter_delay(PH_SP_D1);
            PH_SP_D1: begin
               if (delay_done()) begin
                  sda_out = 1'b1;
                  enter_delay(PH_SP_D2);
               end
            end
            PH_SP_D2: if (delay_done()) phase = PH_SP_WL;
            PH_SP_WL: begin
               if (!t.scl_level) begin
                  phase = PH_IDLE;
                  done  = 1'b1;
               end
            end
            PH_WB_WH: if (t.scl_level) phase = PH_WB_WL;
            PH_WB_WL: begin
               if (!t.scl_level) begin
                  if (bit_count >= BITS_PER_BYTE) begin
                     sda_out = 1'b1;
                     phase   = PH_AK_WH;
                  end else begin
                     enter_delay(PH_WB_D);
                  end
               end
            end
            PH_WB_D: begin
               if (delay_done()) begin
                  sda_out    = shift_byte[7];
                  shift_byte = shift_byte << 1;
                  bit_count  = bit_count + 4'd1;
                  phase      = PH_WB_WH;
               end
            end
            PH_AK_WH: if (t.scl_level) enter_delay(PH_AK_D1);
            PH_AK_D1: begin
               if (delay_done()) begin
                  nack_flag = nack_flag | t.sda_level;
                  phase     = PH_AK_WL;
               end
            end
            PH_AK_WL: if (!t.scl_level) enter_delay(PH_AK_D2);
            PH_AK_D2: begin
               if (delay_done()) begin
                  if (second_pending) begin
                     second_pending = 1'b0;
                     begin_byte(second_byte);
                  end else begin
                     phase = PH_IDLE;
                     done  = 1'b1;
                  end
               end
            end
            default: phase = PH_IDLE;
         endcase
         if (done) begin
            completions++;
            if (nack_flag) nacked++;
         end
         r.sda_drive = sda_out;
         r.busy_res  = (phase != PH_IDLE);
         r.done_res  = done;
         r.nack      = nack_flag;
         expected_responses.push_back(r);
      endfunction

      // compare one response transaction with the oldest expectation
      function void check_response(result_type got);
         result_type want;
         if (expected_responses.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response with nothing outstanding ",
                         "(sda %0b busy %0b done %0b nack %0b)"},
                        got.sda_drive, got.busy_res, got.done_res, got.nack);
            return;
         end
         want = expected_responses.pop_front();
         if (got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res ||
             got.done_res !== want.done_res || got.nack !== want.nack) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: %0t sda exp %0b got %0b, busy exp %0b got %0b, ",
                         "done exp %0b got %0b, nack exp %0b got %0b"},
                        $realtime, want.sda_drive, got.sda_drive,
                        want.busy_res, got.busy_res,
                        want.done_res, got.done_res, want.nack, got.nack);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_byte_value = '0;
   logic [6:0]  req_address = '0;
   logic        req_read_not_write = 1'b0;
   logic [9:0]  req_word_value = '0;
   logic        req_scl_level = 1'b0;
   logic        req_sda_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_nack;

   sda_sequence_scoreboard sb;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   bit         quiet = 1'b0;
   logic       scl_now = 1'b0;
   int         scl_half = 2;
   int         scl_left = 2;
   int         cycle_count = 0;
   result_type observed;

   i2c_master_sda_sequencer_top DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_byte_value     (req_byte_value),
      .req_address        (req_address),
      .req_read_not_write (req_read_not_write),
      .req_word_value     (req_word_value),
      .req_scl_level      (req_scl_level),
      .req_sda_level      (req_sda_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sda_drive      (rsp_sda_drive),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_nack           (rsp_nack)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < receiver_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.sda_drive = rsp_sda_drive;
         observed.busy_res  = rsp_busy_res;
         observed.done_res  = rsp_done_res;
         observed.nack      = rsp_nack;
         sb.check_response(observed);
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // present one tick, hold it until accepted, then predict its response
   task automatic drive_tick(input line_tick_type t);
      while (!quiet && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= t.command;
      req_byte_value     <= t.byte_value;
      req_address        <= t.address;
      req_read_not_write <= t.read_not_write;
      req_word_value     <= t.word_value;
      req_scl_level      <= t.scl_level;
      req_sda_level      <= t.sda_level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(t);
   endtask

   // sender holds off until every expected response has arrived
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // hold delay is only changed with the sequencer idle and drained
   task automatic write_hold(input logic [15:0] value);
      wait_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_hold(value);
   endtask

   // free-running SCL model
   function automatic void advance_scl();
      if (scl_left <= 1) begin
         scl_now  = ~scl_now;
         scl_left = scl_half;
      end else begin
         scl_left--;
      end
   endfunction

   // issue one command and clock the bus until the sequencer is idle again;
   // busy_cmd rides on every later tick and must be ignored
   task automatic run_command(input logic [2:0] cmd, input logic [7:0] bv,
                              input logic [6:0] addr, input logic rnw,
                              input logic [9:0] wv, input logic ack_level,
                              input logic [2:0] busy_cmd);
      line_tick_type t;
      t.command        = cmd;
      t.byte_value     = bv;
      t.address        = addr;
      t.read_not_write = rnw;
      t.word_value     = wv;
      t.scl_level      = scl_now;
      t.sda_level      = ack_level;
      drive_tick(t);
      t.command = busy_cmd;
      while (!sb.is_idle()) begin
         advance_scl();
         t.scl_level = scl_now;
         drive_tick(t);
      end
   endtask

   // framed random traffic: start, address, data, stop, with some noise
   task automatic run_random(input int n);
      line_tick_type t;
      int            frame_step;
      frame_step = 0;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) quiet = ($urandom_range(3) == 0);
         if (i == n / 2 || $urandom_range(199) == 0) wait_drain();
         // mostly brisk SCL, now and then a long stuck level
         scl_half = ($urandom_range(29) == 0) ? $urandom_range(40, 15) : $urandom_range(3, 1);
         advance_scl();
         t.byte_value     = 8'($urandom_range(255));
         t.address        = 7'($urandom_range(127));
         t.read_not_write = 1'($urandom_range(1));
         t.word_value     = 10'($urandom_range(1023));
         t.scl_level      = scl_now;
         t.sda_level      = ($urandom_range(4) == 0);
         t.command        = CMD_NONE;
         if (sb.is_idle()) begin
            if ($urandom_range(2) == 0) begin
               if ($urandom_range(4) == 0) begin
                  t.command = 3'($urandom_range(7));
               end else begin
                  case (frame_step)
                     0: begin
                        t.command  = CMD_START;
                        frame_step = 1;
                     end
                     1: begin
                        t.command  = CMD_ADDRESS;
                        frame_step = 2;
                     end
                     default: begin
                        if ($urandom_range(2) == 0) begin
                           t.command  = CMD_STOP;
                           frame_step = 0;
                        end else begin
                           t.command = $urandom_range(1) ? CMD_BYTE : CMD_WORD;
                        end
                     end
                  endcase
               end
            end
         end else if ($urandom_range(5) == 0) begin
            t.command = 3'($urandom_range(7));
         end
         drive_tick(t);
      end
      // let the last command finish on a running SCL
      scl_half = 2;
      t.command = CMD_NONE;
      while (!sb.is_idle()) begin
         advance_scl();
         t.scl_level = scl_now;
         drive_tick(t);
      end
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // start at the reset hold delay, no idling
      scl_half = 2;
      run_command(CMD_START, 8'h00, 7'h00, 1'b0, 10'h000, 1'b0, CMD_NONE);
      // directed part at a short hold delay
      write_hold(16'd1);
      run_command(CMD_ADDRESS, 8'h00, 7'h7F, 1'b1, 10'h000, 1'b0, CMD_BYTE);
      run_command(CMD_BYTE, 8'hFF, 7'h00, 1'b0, 10'h000, 1'b1, CMD_NONE);
      run_command(CMD_BYTE, 8'h00, 7'h00, 1'b0, 10'h000, 1'b0, CMD_WORD);
      run_command(CMD_WORD, 8'hAA, 7'h55, 1'b0, 10'h3FF, 1'b1, CMD_STOP);
      run_command(CMD_WORD, 8'h55, 7'h2A, 1'b1, 10'h000, 1'b0, CMD_UNUSED_SVN);
      run_command(CMD_UNUSED_SIX, 8'hFF, 7'h7F, 1'b1, 10'h3FF, 1'b1, CMD_NONE);
      run_command(CMD_UNUSED_SVN, 8'h00, 7'h00, 1'b0, 10'h000, 1'b0, CMD_NONE);
      run_command(CMD_ADDRESS, 8'h5A, 7'h00, 1'b0, 10'h2AA, 1'b0, CMD_UNUSED_SIX);
      run_command(CMD_STOP, 8'h00, 7'h00, 1'b0, 10'h000, 1'b0, CMD_START);
      // slow SCL: long waits in the level-wait phases
      scl_half = 8;
      run_command(CMD_START, 8'h00, 7'h00, 1'b0, 10'h000, 1'b0, CMD_NONE);
      run_command(CMD_BYTE, 8'hC3, 7'h00, 1'b0, 10'h155, 1'b1, CMD_ADDRESS);

      // random phases under different idling patterns and hold delays
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: write_hold(16'd0);
            1: write_hold(16'd1);
            2: write_hold(16'd2);
            default: write_hold(16'($urandom_range(4)));
         endcase
         sender_idle_pct    = (p == 1) ? 71 : (p == 3) ? 37 : 0;
         receiver_stall_pct = (p == 2) ? 71 : (p == 3) ? 37 : 0;
         run_random(RANDOM_TICKS);
      end

      // longer hold delay: one stop condition, no idling
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_hold(16'd64);
      scl_half = 20;
      run_command(CMD_STOP, 8'h00, 7'h00, 1'b0, 10'h000, 1'b0, CMD_NONE);

      wait_drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d bus ticks, %0d commands completed (start %0d, stop %0d,",
               sb.ticks, sb.completions, sb.commands_taken[CMD_START],
               sb.commands_taken[CMD_STOP]);
      $display("byte %0d, address %0d, word %0d), %0d unused codes seen idle.",
               sb.commands_taken[CMD_BYTE], sb.commands_taken[CMD_ADDRESS],
               sb.commands_taken[CMD_WORD],
               sb.commands_taken[CMD_UNUSED_SIX] + sb.commands_taken[CMD_UNUSED_SVN]);
      $display("Hold delays 0 to 4, 16 and 64 used; %0d transfers ended with NACK.",
               sb.nacked);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
